// ===== rtl/core/range_calc_with_correction_table_macros.svh =====
// ----------------------------------------------------------------------------
// Range calculator assertion macros
// Short forms for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_CALC_WITH_CORRECTION_TABLE_MACROS_SVH
`define RANGE_CALC_WITH_CORRECTION_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Range calculator package
// Constants, field widths and the input word layout shared by the design.
// ----------------------------------------------------------------------------
package rcc_pkg;

    // Correction table geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int SEGMENT_BITS  = 11;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
    localparam int TBL_DEPTH     = 2 * TABLE_ENTRIES;
    localparam int SEG_SPAN      = 1 << SEGMENT_BITS;

    // Fixed-point layout of the range calculation.
    localparam int SCALE_SHIFT  = 3;
    localparam int DELAY_FRAC   = 12;
    localparam int RANGE_SHIFT  = 13;
    localparam int RANGE_W      = 32;
    localparam int WORD_W       = 16;
    localparam int COUNT_W      = 32;
    localparam int DELAY_W      = 16;
    localparam int SC_W         = 32 - SCALE_SHIFT;
    localparam int PROD_CNT_W   = COUNT_W + 1 + SC_W;
    localparam int PROD_DEL_W   = DELAY_W + 1 + SC_W;
    localparam int DIFF_DEL_W   = PROD_DEL_W + 1;
    localparam int SUM_W        = RANGE_W + RANGE_SHIFT;
    localparam int WPROD_W      = WORD_W + SEGMENT_BITS + 2;
    localparam int CORR_W       = WPROD_W + 1;

    // Input word kinds carried in s_tuser.
    localparam logic FUNC_TABLE_WRITE = 1'b0;
    localparam logic FUNC_MEASURE     = 1'b1;

    // Configuration register indexes.
    localparam int   CFG_IDX_W      = 1;
    localparam logic CFG_IDX_SCALE  = 1'b0;
    localparam logic CFG_IDX_OFFSET = 1'b1;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 32;

    // Input word, last field in the lowest bits.
    typedef struct packed {
        logic [5:0]                pad;
        logic [DELAY_W-1:0]        delay_raw;
        logic [COUNT_W-1:0]        sample_count;
        logic                      ref_flag;
        logic [1:0]                position;
        logic signed [WORD_W-1:0]  table_word;
        logic [5:0]                table_index;
        logic                      table_select;
    } in_word_t;

endpackage

// ===== rtl/core/range_calc_with_correction_table.sv =====
// ----------------------------------------------------------------------------
// Range calculator with correction tables
// Turns measurement words into ranges, corrects them through per-channel
// piecewise-linear tables and delivers the mean of both channels.
// ----------------------------------------------------------------------------
// A table word (s_tuser low) is written into the correction memory at the
// accepting edge, so table words can stream at one per cycle while the
// block is idle. A measurement word (s_tuser high) is worked on alone: it
// holds the input from state MUL through FIN, skipping RD1, CORR and ADD
// when its range falls outside the table. This is set by the single-port
// correction memory, which is read twice in succession for the two
// neighbouring table entries, and by the chain of a scaling multiplier, the
// reference subtraction, the range sum and the interpolation multipliers,
// one register stage each. After the fourth measurement of a job
// (position 3) the averaged range is placed in an output register; the
// block goes on accepting words while that result waits, and stalls only
// if a new job finishes before the previous result has been taken. The
// configuration port is always ready and should be written only while the
// block is idle. After reset all table entries read as zero until written.

module range_calc_with_correction_table (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata from bit 0 up: table_select, table_index, table_word, position,
    // ref_flag, sample_count, delay_raw, zero padding.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rcc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: func.
    input  logic                               s_tuser,
    // m_tdata: averaged_range.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rcc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data
);
    import rcc_pkg::*;

    // Sequencer states of one measurement.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_SUB  = 4'd2;
    localparam logic [3:0] ST_SUM  = 4'd3;
    localparam logic [3:0] ST_RD0  = 4'd4;
    localparam logic [3:0] ST_RD1  = 4'd5;
    localparam logic [3:0] ST_CORR = 4'd6;
    localparam logic [3:0] ST_ADD  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0]                     state_reg;

    // Configuration registers.
    logic signed [31:0]             scale_reg;
    logic signed [31:0]             offset_reg;

    // Held measurement and datapath stages.
    in_word_t                       item_reg;
    logic signed [PROD_CNT_W-1:0]   prod_cnt_reg;
    logic signed [PROD_DEL_W-1:0]   prod_del_reg;
    logic signed [PROD_CNT_W-1:0]   ref_cnt_reg;
    logic signed [PROD_DEL_W-1:0]   ref_del_reg;
    logic [SUM_W-1:0]               diff_cnt_reg;
    logic signed [DIFF_DEL_W-1:0]   diff_del_reg;
    logic [RANGE_W-1:0]             range_reg;
    logic signed [WORD_W-1:0]       n0_reg;
    logic signed [WPROD_W-1:0]      p0_reg;
    logic signed [WPROD_W-1:0]      p1_reg;
    logic [RANGE_W-1:0]             result_reg;
    logic [RANGE_W-1:0]             chan_a_reg;
    logic                           m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]         m_tdata_reg;

    // Correction memory: channel A in the lower half, channel B in the upper.
    logic signed [WORD_W-1:0]       tbl_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0]           tbl_valid_reg;
    logic signed [WORD_W-1:0]       rd_data_reg;
    logic                           rd_valid_reg;

    in_word_t                       in_word;
    logic                           s_accept;
    logic                           tbl_wr;
    logic [TBL_AW:0]                wr_addr;
    logic [TBL_AW:0]                rd_addr;
    logic [TBL_AW-1:0]              seg;
    logic                           seg_ok;
    logic [SEGMENT_BITS-1:0]        phase;
    logic [SEGMENT_BITS:0]          weight0;
    logic signed [WORD_W-1:0]       rd_word;
    logic signed [SC_W-1:0]         sc;
    logic signed [PROD_CNT_W-1:0]   ref_cnt_used;
    logic signed [PROD_DEL_W-1:0]   ref_del_used;
    logic signed [PROD_CNT_W-1:0]   cnt_diff;
    logic signed [DIFF_DEL_W-1:0]   del_diff;
    logic signed [DIFF_DEL_W-1:0]   del_shifted;
    logic [SUM_W-1:0]               sum;
    logic signed [CORR_W-1:0]       corr;
    logic signed [CORR_W-1:0]       corr_shifted;
    logic [RANGE_W:0]               pair_total;
    logic                           out_busy;
    logic                           out_load;
    logic                           is_last;

    assign in_word   = in_word_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Table writes land directly at the accepting edge; reads only happen
    // while a measurement holds the input, so the two never meet.
    assign tbl_wr  = s_accept && (s_tuser == FUNC_TABLE_WRITE) &&
                     (32'(in_word.table_index) < 32'(TABLE_ENTRIES));
    assign wr_addr = {in_word.table_select, TBL_AW'(in_word.table_index)};

    // Segment and phase of the uncorrected range. The range is corrected
    // only when the segment has a right-hand neighbour in the table.
    assign seg     = range_reg[SEGMENT_BITS +: TBL_AW];
    assign phase   = range_reg[SEGMENT_BITS-1:0];
    assign seg_ok  = range_reg[RANGE_W-1:SEGMENT_BITS] <
                     (RANGE_W-SEGMENT_BITS)'(TABLE_ENTRIES - 1);
    assign rd_addr = {item_reg.position[1],
                      (state_reg == ST_RD1) ? TBL_AW'(seg + 1'b1) : seg};
    assign rd_word = rd_valid_reg ? rd_data_reg : '0;
    assign weight0 = (SEGMENT_BITS+1)'(SEG_SPAN) - {1'b0, phase};

    // Scale factor is used with its three fraction bits dropped (floor).
    assign sc = $signed(scale_reg[31:SCALE_SHIFT]);

    // The reference is cleared at the first position of each channel.
    assign ref_cnt_used = item_reg.position[0] ? ref_cnt_reg : '0;
    assign ref_del_used = item_reg.position[0] ? ref_del_reg : '0;
    assign cnt_diff     = prod_cnt_reg - ref_cnt_used;
    assign del_diff     = DIFF_DEL_W'(prod_del_reg) - DIFF_DEL_W'(ref_del_used);

    // Only bits above the final shift survive, so the sum is kept modulo
    // 2^(32+13) and the offset enters as offset * 8192.
    assign del_shifted = diff_del_reg >>> DELAY_FRAC;
    assign sum = diff_cnt_reg - SUM_W'(del_shifted) + {offset_reg, {RANGE_SHIFT{1'b0}}};

    assign corr         = CORR_W'(p0_reg) + CORR_W'(p1_reg);
    assign corr_shifted = corr >>> SEGMENT_BITS;

    assign pair_total = {1'b0, chan_a_reg} + {1'b0, result_reg};
    assign out_busy   = m_tvalid_reg && !m_tready;
    assign is_last    = (item_reg.position == 2'd3);
    // A finished job loads the output register; this may coincide with the
    // previous word being taken.
    assign out_load   = (state_reg == ST_FIN) && is_last && !out_busy;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= '0;
            offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_IDX_SCALE:  scale_reg  <= $signed(cfg_data);
                CFG_IDX_OFFSET: offset_reg <= $signed(cfg_data);
            endcase
        end
    end

    // Correction memory with registered read data.
    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            tbl_mem[wr_addr] <= in_word.table_word;
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    // Entry valid bits: an entry never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= tbl_valid_reg[rd_addr];
            if (tbl_wr) begin
                tbl_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Sequencer, references, channel A range and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ref_cnt_reg  <= '0;
            ref_del_reg  <= '0;
            chan_a_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_tuser == FUNC_MEASURE)) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_SUB;
                end
                ST_SUB: begin
                    if (item_reg.ref_flag) begin
                        ref_cnt_reg <= prod_cnt_reg;
                        ref_del_reg <= prod_del_reg;
                    end else if (!item_reg.position[0]) begin
                        ref_cnt_reg <= '0;
                        ref_del_reg <= '0;
                    end
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    state_reg <= ST_RD0;
                end
                ST_RD0: begin
                    state_reg <= seg_ok ? ST_RD1 : ST_FIN;
                end
                ST_RD1: begin
                    state_reg <= ST_CORR;
                end
                ST_CORR: begin
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (!(is_last && out_busy)) begin
                        if (item_reg.position == 2'd1) begin
                            chan_a_reg <= result_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_accept && (s_tuser == FUNC_MEASURE)) begin
            item_reg <= in_word;
        end
        if (state_reg == ST_MUL) begin
            prod_cnt_reg <= $signed({1'b0, item_reg.sample_count}) * sc;
            prod_del_reg <= $signed({1'b0, item_reg.delay_raw}) * sc;
        end
        if (state_reg == ST_SUB) begin
            if (item_reg.ref_flag) begin
                diff_cnt_reg <= prod_cnt_reg[SUM_W-1:0];
                diff_del_reg <= DIFF_DEL_W'(prod_del_reg);
            end else begin
                diff_cnt_reg <= cnt_diff[SUM_W-1:0];
                diff_del_reg <= del_diff;
            end
        end
        if (state_reg == ST_SUM) begin
            range_reg <= sum[SUM_W-1:RANGE_SHIFT];
        end
        if ((state_reg == ST_RD0) && !seg_ok) begin
            result_reg <= range_reg;
        end
        if (state_reg == ST_RD1) begin
            n0_reg <= rd_word;
        end
        if (state_reg == ST_CORR) begin
            p0_reg <= n0_reg * $signed({1'b0, weight0});
            p1_reg <= rd_word * $signed({2'b00, phase});
        end
        if (state_reg == ST_ADD) begin
            result_reg <= range_reg + RANGE_W'(corr_shifted);
        end
        if (out_load) begin
            m_tdata_reg <= pair_total[RANGE_W:1];
        end
    end

endmodule

// ===== rtl/core/rcc_checker.sv =====
// ----------------------------------------------------------------------------
// Range calculator port checker
// Watches the stream ports of the range calculator over time.
// ----------------------------------------------------------------------------
`include "range_calc_with_correction_table_macros.svh"

module rcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result word stays offered and unchanged.
    `RCC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
    `RCC_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result word changed while stalled")

    // A measurement occupies the block, a table word does not.
    `RCC_ASSERT_NEXT(a_meas_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser, !s_tready, "input still ready after a measurement word")
    `RCC_ASSERT_NEXT(a_write_ready, aclk, aresetn, s_tvalid && s_tready && !s_tuser, s_tready, "input not ready after a table word")

endmodule

bind range_calc_with_correction_table rcc_checker u_rcc_checker (.*);

// ===== tb/range_calc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range calculator checker
// Watches the input, result and register channels of the range calculator.
// It keeps its own copy of the scale, offset, references and correction
// tables, works out the averaged range for every finished job and compares
// it with the words that leave the block, in order.
// ----------------------------------------------------------------------------
module range_calc_checker
    import rcc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    input  logic                    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_TDATA_W-1:0]  m_tdata,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]             cfg_data,
    output int                      mismatch_count,
    output int                      ranges_pending
);

    longint                   scale_q;
    longint                   offset_q;
    longint                   ref_count;
    longint                   ref_delay;
    logic [31:0]              channel_a;
    logic signed [WORD_W-1:0] corr_tbl [2][TABLE_ENTRIES];
    logic [31:0]              avg_expected [$];
    int                       mismatch_tally;

    // Corrected range of one measurement; updates the references when the
    // measurement is flagged as the reference point.
    function automatic logic [31:0] channel_range(input logic tbl, input logic is_ref,
                                                  input logic [31:0] count,
                                                  input logic [15:0] delay);
        longint      sc;
        longint      cnt;
        longint      del;
        longint      sum;
        longint      wide;
        longint      phase;
        longint      n0;
        longint      n1;
        longint      rl;
        longint      v;
        logic [31:0] rng;
        logic [31:0] seg;

        sc  = scale_q >>> SCALE_SHIFT;
        cnt = count;
        cnt = cnt * sc;
        del = delay;
        del = del * sc;
        if (is_ref) begin
            ref_count = cnt;
            ref_delay = del;
        end else begin
            cnt = cnt - ref_count;
            del = del - ref_delay;
        end
        sum  = cnt - (del >>> DELAY_FRAC) + (offset_q <<< RANGE_SHIFT);
        wide = sum >>> RANGE_SHIFT;
        rng  = wide[31:0];
        seg  = rng >> SEGMENT_BITS;
        if (seg < TABLE_ENTRIES - 1) begin
            phase = rng[SEGMENT_BITS-1:0];
            n0    = corr_tbl[tbl][seg];
            n1    = corr_tbl[tbl][seg + 1];
            rl    = rng;
            v     = rl * SEG_SPAN + n0 * (SEG_SPAN - phase) + n1 * phase;
            wide  = v >>> SEGMENT_BITS;
            rng   = wide[31:0];
        end
        return rng;
    endfunction

    always @(posedge aclk) begin : track
        in_word_t    w;
        logic [31:0] rng;
        logic [31:0] want;
        logic [32:0] total;

        if (!aresetn) begin
            scale_q   = 0;
            offset_q  = 0;
            ref_count = 0;
            ref_delay = 0;
            channel_a = '0;
            for (int t = 0; t < 2; t++) begin
                for (int e = 0; e < TABLE_ENTRIES; e++) begin
                    corr_tbl[t][e] = '0;
                end
            end
            avg_expected.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (avg_expected.size() == 0) begin
                    mismatch_tally++;
                    $error("averaged_range: expected nothing, actual %0d", m_tdata);
                end else begin
                    want = avg_expected.pop_front();
                    if (m_tdata !== want) begin
                        mismatch_tally++;
                        $error("averaged_range: expected %0d, actual %0d", want, m_tdata);
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_IDX_SCALE) begin
                    scale_q = longint'($signed(cfg_data));
                end else begin
                    offset_q = longint'($signed(cfg_data));
                end
            end

            if (s_tvalid && s_tready) begin
                w = s_tdata;
                if (s_tuser == FUNC_TABLE_WRITE) begin
                    corr_tbl[w.table_select][w.table_index] = w.table_word;
                end else begin
                    // Each channel starts from a zero reference.
                    if (w.position == 2'd0 || w.position == 2'd2) begin
                        ref_count = 0;
                        ref_delay = 0;
                    end
                    rng = channel_range(w.position[1], w.ref_flag, w.sample_count,
                                        w.delay_raw);
                    if (w.position == 2'd1) begin
                        channel_a = rng;
                    end
                    if (w.position == 2'd3) begin
                        total = {1'b0, channel_a} + {1'b0, rng};
                        avg_expected.push_back(total[32:1]);
                    end
                end
            end
        end
        mismatch_count <= mismatch_tally;
        ranges_pending <= avg_expected.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range calculator testbench
// Drives table and measurement words into the range calculator in bursts,
// stalls the result side on a pattern of its own and steps through a series
// of scale and offset settings. A checker beside the block predicts every
// averaged range; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import rcc_pkg::*;

    // Longest stretch without any handshake before the run is declared hung.
    // The slowest legal stretch is a sender gap, a measurement and a long
    // receiver stall.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Cycles a measurement with no result may still be in flight.
    localparam int SETTLE_CYCLES   = 16;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 180;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [31:0]             cfg_data  = '0;

    int mismatch_count;
    int ranges_pending;
    int burst_left;
    int words_sent;
    int idle_cycles;
    int rx_left;
    int measure_words;
    int table_words;
    int ranges_seen;
    int settings_done;

    range_calc_with_correction_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    range_calc_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .ranges_pending (ranges_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The receiver alternates runs of readiness with stalls whose length is
    // drawn from several classes, one of which is no stall at all.
    always @(posedge aclk) begin : rx_pattern
        int stall_len;

        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_left  <= 0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (m_tready) begin
            case ($urandom_range(0, 3))
                0:       stall_len = 0;
                1:       stall_len = $urandom_range(1, 3);
                2:       stall_len = $urandom_range(4, 12);
                default: stall_len = $urandom_range(20, 40);
            endcase
            if (stall_len != 0) begin
                m_tready <= 1'b0;
                rx_left  <= stall_len - 1;
            end else begin
                rx_left <= $urandom_range(0, 20);
            end
        end else begin
            m_tready <= 1'b1;
            rx_left  <= $urandom_range(0, 30);
        end
    end

    // Watchdog and tallies for the closing summary. Any accepted word on any
    // channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_MEASURE) begin
                    measure_words <= measure_words + 1;
                end else begin
                    table_words <= table_words + 1;
                end
            end
            if (m_tvalid && m_tready) begin
                ranges_seen <= ranges_seen + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: hung for %0d cycles", idle_cycles);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // An input word with every field but the padding random; callers then
    // fix the fields that matter, so the ignored ones still carry noise.
    function automatic in_word_t noise_word();
        in_word_t w;

        w.pad          = '0;
        w.delay_raw    = 16'($urandom);
        w.sample_count = $urandom;
        w.ref_flag     = 1'($urandom);
        w.position     = 2'($urandom);
        w.table_word   = 16'($urandom);
        w.table_index  = 6'($urandom);
        w.table_select = 1'($urandom);
        return w;
    endfunction

    // Sends one word. The sender works in bursts; between bursts valid is
    // dropped for a random gap, which may also be nothing at all.
    task automatic push_word(input logic kind, input in_word_t w);
        int gap;

        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        words_sent++;
    endtask

    task automatic table_write(input logic sel, input logic [5:0] idx,
                               input logic [15:0] word);
        in_word_t w;

        w              = noise_word();
        w.table_select = sel;
        w.table_index  = idx;
        w.table_word   = word;
        push_word(FUNC_TABLE_WRITE, w);
    endtask

    task automatic take_measurement(input logic [1:0] pos, input logic is_ref,
                                    input logic [31:0] count, input logic [15:0] delay);
        in_word_t w;

        w              = noise_word();
        w.position     = pos;
        w.ref_flag     = is_ref;
        w.sample_count = count;
        w.delay_raw    = delay;
        push_word(FUNC_MEASURE, w);
    endtask

    // Holds the sender until every averaged range has come out, then lets a
    // measurement that produces no result run through the block.
    task automatic wait_all_ranges();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (ranges_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Both registers in one go, valid held high across the two words.
    task automatic set_registers(input logic [31:0] scale, input logic [31:0] offset);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_SCALE;
        cfg_data  <= scale;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_IDX_OFFSET;
        cfg_data  <= offset;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // A well-formed job: four measurements in order, reference flags mostly
    // on the first word of each channel, table updates now and then between
    // the words. Counts sit near a common base so that differences against
    // the reference often land inside the correction table.
    task automatic run_job();
        logic [31:0] base;
        logic [31:0] count;
        logic        is_ref;

        case ($urandom_range(0, 3))
            0:       base = $urandom;
            1:       base = $urandom_range(0, 32'h3FFF_FFFF);
            2:       base = '0;
            default: base = 32'hFFFF_FFFF - $urandom_range(0, 32'h000F_FFFF);
        endcase
        for (int p = 0; p < 4; p++) begin
            if ($urandom_range(0, 4) == 0) begin
                table_write(1'($urandom), 6'($urandom), 16'($urandom));
            end
            is_ref = (p % 2 == 0) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) == 0);
            if (is_ref) begin
                count = base;
            end else begin
                case ($urandom_range(0, 3))
                    0:       count = base + $urandom_range(0, 32'h4000_0000);
                    1:       count = $urandom;
                    2:       count = base - $urandom_range(0, 32'h0100_0000);
                    default: count = base + $urandom_range(0, 32'h0010_0000);
                endcase
            end
            take_measurement(2'(p), is_ref, count, 16'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [31:0] scale_set;
        logic [31:0] offset_set;
        int          phase_start;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with a unit scale: extreme table words at both ends
        // of both tables, then measurements with extreme counts and delays.
        set_registers(32'd8, 32'd0);
        table_write(1'b0, 6'd0, 16'sh7FFF);
        table_write(1'b0, 6'd1, 16'sh8000);
        table_write(1'b0, 6'd63, 16'hFFFF);
        table_write(1'b1, 6'd0, 16'sh8000);
        table_write(1'b1, 6'd1, 16'd100);
        table_write(1'b1, 6'd63, 16'sh7FFF);
        table_write(1'b0, 6'd62, 16'd1234);
        // Ranges in the first segment, and a count so large the range falls
        // past the table.
        take_measurement(2'd0, 1'b1, 32'd0, 16'd0);
        take_measurement(2'd1, 1'b0, 32'h0000_1000, 16'hFFFF);
        take_measurement(2'd2, 1'b0, 32'hFFFF_FFFF, 16'd0);
        take_measurement(2'd3, 1'b1, 32'h0100_0000, 16'hFFFF);
        // Measurements below their reference: negative ranges that wrap.
        take_measurement(2'd0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        take_measurement(2'd1, 1'b0, 32'd0, 16'd0);
        take_measurement(2'd2, 1'b1, 32'd200000, 16'd100);
        take_measurement(2'd3, 1'b0, 32'd100000, 16'd0);
        // Last segment that still interpolates, and the first that does not.
        take_measurement(2'd0, 1'b0, 32'd0, 16'd0);
        take_measurement(2'd1, 1'b0, 32'd127976 << 13, 16'h0800);
        take_measurement(2'd2, 1'b0, 32'd0, 16'd0);
        take_measurement(2'd3, 1'b0, 32'd129024 << 13, 16'd0);
        // Positions out of order: a lone channel B word, a repeated channel A
        // slot and a job left unfinished.
        take_measurement(2'd3, 1'b0, 32'd5000, 16'd0);
        take_measurement(2'd1, 1'b1, 32'd7, 16'd7);
        take_measurement(2'd1, 1'b0, 32'd300 << 13, 16'd0);
        take_measurement(2'd2, 1'b1, 32'd0, 16'd0);
        wait_all_ranges();

        // Random part, one register setting per phase, extremes included.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    scale_set  = 32'd8;
                    offset_set = 32'd0;
                end
                1: begin
                    scale_set  = 32'h7FFF_FFFF;
                    offset_set = 32'h7FFF_FFFF;
                end
                2: begin
                    scale_set  = 32'h8000_0000;
                    offset_set = 32'h8000_0000;
                end
                3: begin
                    scale_set  = 32'hFFFF_FFF8;
                    offset_set = 32'd20;
                end
                4: begin
                    // Scale of zero: the range is the offset alone, swept
                    // across the whole table.
                    scale_set  = $urandom_range(0, 7);
                    offset_set = $urandom_range(0, 140000);
                end
                5: begin
                    scale_set  = $urandom_range(8, 64);
                    offset_set = 32'($urandom_range(0, 2000)) - 32'd1000;
                end
                6: begin
                    scale_set  = $urandom;
                    offset_set = $urandom;
                end
                default: begin
                    scale_set  = 32'd8;
                    offset_set = 32'hFFFF_FFFF;
                end
            endcase
            set_registers(scale_set, offset_set);
            phase_start = words_sent;
            while (words_sent - phase_start < ITEMS_PER_PHASE) begin
                case ($urandom_range(0, 19)) inside
                    [0:13]: run_job();
                    [14:16]: begin
                        repeat ($urandom_range(1, 4)) begin
                            table_write(1'($urandom), 6'($urandom), 16'($urandom));
                        end
                    end
                    default: begin
                        take_measurement(2'($urandom), 1'($urandom), $urandom,
                                         16'($urandom));
                    end
                endcase
            end
            wait_all_ranges();
        end

        $display("tb_top: %0d measurement and %0d table words over %0d register settings",
                 measure_words, table_words, settings_done);
        $display("tb_top: %0d averaged ranges compared, %0d mismatches",
                 ranges_seen, mismatch_count);
        if (mismatch_count == 0 && ranges_pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== range_calc_with_correction_table.f =====
+incdir+rtl/core
rtl/core/rcc_pkg.sv
rtl/core/range_calc_with_correction_table.sv
rtl/core/rcc_checker.sv
tb/range_calc_checker.sv
tb/tb_top.sv
